// ----- design/irpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared constants and helpers for the IR pulse distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CAPTURE_BITS = 16;
   localparam int FRAME_BITS = 32;
   localparam int POS_BITS = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [7:0] LEADER_WIDTH_RESET = 8'd90;
   localparam logic [4:0] LEADER_TOLERANCE_RESET = 5'd5;
   localparam logic [7:0] ONE_THRESHOLD_RESET = 8'd20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEADER_WIDTH = 2'd0,
      CSR_LEADER_TOLERANCE = 2'd1,
      CSR_ONE_THRESHOLD = 2'd2
   } csr_index_type;

   // Received byte k lands at code bits 31-8k down to 24-8k.
   function automatic logic [FRAME_BITS-1:0] pack_code(input logic [FRAME_BITS-1:0] bits);
      return {bits[7:0], bits[15:8], bits[23:16], bits[31:24]};
   endfunction

endpackage
`default_nettype wire

// ----- design/ir_pulse_distance_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_unit
// Decodes 32 bit pulse distance IR frames from captured edge timestamps.
// ----------------------------------------------------------------------------
// An accepted item passes the input register and then the result register.
// Throughput is one item per cycle while rsp_stall is low, set by the single
// decode stage between the input register and the result register.
// Synchronous active high reset clears the frame state, the frame counter,
// the input and output valid flags and restores the register defaults.
module ir_pulse_distance_decoder_unit
   import irpd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [CAPTURE_BITS-1:0]   req_capture_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_code_valid,
   output logic [FRAME_BITS-1:0]          rsp_code,
   output logic                           rsp_restart_timer,
   output logic [FRAME_BITS-1:0]          rsp_frame_count
);

   localparam int CMP_BITS = COUNT_BITS + 1;

   logic [7:0] leader_width_ff;
   logic [4:0] leader_tolerance_ff;
   logic [7:0] one_threshold_ff;

   logic                    in_valid_ff;
   logic [CAPTURE_BITS-1:0] in_capture_ff;

   logic [COUNT_BITS-1:0] previous_capture_ff, previous_capture_in;
   logic [POS_BITS-1:0]   bit_position_ff, bit_position_in;
   logic                  in_frame_ff, in_frame_in;
   logic [FRAME_BITS-1:0] collected_bits_ff, collected_bits_in;
   logic [FRAME_BITS-1:0] frames_decoded_ff, frames_decoded_in;

   logic                  out_valid_ff;
   logic                  code_valid_ff, code_valid_in;
   logic [FRAME_BITS-1:0] code_ff, code_in;
   logic                  restart_ff, restart_in;

   logic                  advance;
   logic [31:0]           capture_ext;
   logic [COUNT_BITS-1:0] now;
   logic [COUNT_BITS-1:0] width;
   logic [CMP_BITS-1:0]   width_ext;
   logic [CMP_BITS-1:0]   lw_ext;
   logic [CMP_BITS-1:0]   tol_ext;
   logic                  is_leader;
   logic                  bit_value;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign capture_ext = {{(32 - CAPTURE_BITS){1'b0}}, in_capture_ff};
   assign now = capture_ext[COUNT_BITS-1:0];
   assign width = now - previous_capture_ff;
   assign width_ext = CMP_BITS'(width);
   assign lw_ext = CMP_BITS'(leader_width_ff);
   assign tol_ext = CMP_BITS'(leader_tolerance_ff);
   assign is_leader = (width_ext + tol_ext > lw_ext) && (width_ext < lw_ext + tol_ext);
   assign bit_value = width_ext > CMP_BITS'(one_threshold_ff);

   always_comb begin
      previous_capture_in = now;
      bit_position_in = bit_position_ff;
      in_frame_in = in_frame_ff;
      collected_bits_in = collected_bits_ff;
      frames_decoded_in = frames_decoded_ff;
      code_valid_in = 1'b0;
      code_in = '0;
      restart_in = 1'b0;
      if (is_leader) begin
         previous_capture_in = '0;
         bit_position_in = '0;
         in_frame_in = 1'b1;
         restart_in = 1'b1;
      end else if (in_frame_ff) begin
         collected_bits_in[bit_position_ff] = bit_value;
         if (bit_position_ff == POS_BITS'(FRAME_BITS - 1)) begin
            bit_position_in = '0;
            in_frame_in = 1'b0;
            frames_decoded_in = frames_decoded_ff + 1'b1;
            code_valid_in = 1'b1;
            code_in = pack_code(collected_bits_in);
         end else begin
            bit_position_in = bit_position_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_width_ff <= LEADER_WIDTH_RESET;
         leader_tolerance_ff <= LEADER_TOLERANCE_RESET;
         one_threshold_ff <= ONE_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LEADER_WIDTH: begin
               leader_width_ff <= csr_write_data;
            end
            CSR_LEADER_TOLERANCE: begin
               leader_tolerance_ff <= csr_write_data[4:0];
            end
            CSR_ONE_THRESHOLD: begin
               one_threshold_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_capture_ff <= req_capture_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_capture_ff <= '0;
         bit_position_ff <= '0;
         in_frame_ff <= 1'b0;
         collected_bits_ff <= '0;
         frames_decoded_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            previous_capture_ff <= previous_capture_in;
            bit_position_ff <= bit_position_in;
            in_frame_ff <= in_frame_in;
            collected_bits_ff <= collected_bits_in;
            frames_decoded_ff <= frames_decoded_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         code_valid_ff <= code_valid_in;
         code_ff <= code_in;
         restart_ff <= restart_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_code_valid = code_valid_ff;
   assign rsp_code = code_ff;
   assign rsp_restart_timer = restart_ff;
   assign rsp_frame_count = frames_decoded_ff;

endmodule
`default_nettype wire
